// ===== src/byte_stuff_deframer_crc16_unit_assert.svh =====
// Assertion macros for the byte-stuffed deframer.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef BYTE_STUFF_DEFRAMER_CRC16_UNIT_ASSERT_SVH
`define BYTE_STUFF_DEFRAMER_CRC16_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define BSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define BSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bsd_pkg.sv =====
// Shared types, register indexes and the CRC-16/ARC byte step for the deframer.
// No dependencies.
`timescale 1ns / 1ps

package bsd_pkg;

  // Receive phase of the deframer
  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_DATA   = 3'd1,
    PH_ESC    = 3'd2,
    PH_CRC_HI = 3'd3,
    PH_CRC_LO = 3'd4
  } phase_e;

  // Configuration register indexes
  localparam logic [1:0] REG_START_CODE  = 2'd0;
  localparam logic [1:0] REG_END_CODE    = 2'd1;
  localparam logic [1:0] REG_ESCAPE_CODE = 2'd2;
  localparam logic [1:0] REG_MAX_LENGTH  = 2'd3;

  // Output item kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

  typedef struct packed {
    logic [7:0]  start_code;
    logic [7:0]  end_code;
    logic [7:0]  escape_code;
    logic [12:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [12:0] frame_length;
    logic        crc_match;
    logic        overflowed;
  } res_t;

  // One byte through the reflected CRC-16/ARC register
  function automatic logic [15:0] crc16_arc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/bsd_deframe_core.sv =====
// Deframer state machine: escape handling, running CRC, length count, overflow.
// Depends on bsd_pkg.
`timescale 1ns / 1ps

module bsd_deframe_core import bsd_pkg::*; #(
  parameter int MAX_FRAME = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       beat_i,
  input  logic [7:0] rx_byte_i,
  input  cfg_t       cfg_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  // Count never exceeds the smaller of MAX_FRAME and the largest max_length
  localparam int          CAP_INT = (MAX_FRAME < 8191) ? MAX_FRAME : 8191;
  localparam int          CNT_W   = $clog2(CAP_INT + 1);
  localparam logic [12:0] LIM_CAP = 13'(CAP_INT);

  phase_e             phase_q, phase_d;
  logic [15:0]        crc_q, crc_d;
  logic [7:0]         crc_hi_q, crc_hi_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               ovf_q, ovf_d;

  logic               is_start, is_end, is_esc;
  logic               take_byte, room;
  logic [12:0]        lim13;
  logic [CNT_W-1:0]   limit;
  logic [15:0]        crc_upd;

  assign is_start = (rx_byte_i == cfg_i.start_code);
  assign is_end   = (rx_byte_i == cfg_i.end_code);
  assign is_esc   = (rx_byte_i == cfg_i.escape_code);

  // Effective limit, capped at the build-time frame size
  assign lim13 = (cfg_i.max_length > LIM_CAP) ? LIM_CAP : cfg_i.max_length;
  assign limit = lim13[CNT_W-1:0];
  assign room  = (cnt_q < limit);

  assign crc_upd = crc16_arc_byte(crc_q, rx_byte_i);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_WAIT:   if (is_start) phase_d = PH_DATA;
      PH_DATA: begin
        if (is_end) phase_d = PH_CRC_HI;
        else if (is_esc) phase_d = PH_ESC;
      end
      PH_ESC:    phase_d = PH_DATA;
      PH_CRC_HI: phase_d = PH_CRC_LO;
      PH_CRC_LO: phase_d = PH_WAIT;
      default:   phase_d = PH_WAIT;
    endcase
  end

  // Datapath and result for the current byte
  always_comb begin
    take_byte   = 1'b0;
    crc_d       = crc_q;
    crc_hi_d    = crc_hi_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (phase_q)
      PH_WAIT: begin
        if (is_start) begin
          crc_d = '0;
          cnt_d = '0;
          ovf_d = 1'b0;
        end
      end
      PH_DATA: begin
        if (!is_end) begin
          crc_d     = crc_upd;
          take_byte = !is_esc;
        end
      end
      PH_ESC: begin
        if (is_esc || is_end || is_start) begin
          crc_d     = crc_upd;
          take_byte = 1'b1;
        end
      end
      PH_CRC_HI: crc_hi_d = rx_byte_i;
      PH_CRC_LO: begin
        res_valid_o        = 1'b1;
        res_o.item_kind    = KIND_END;
        res_o.frame_length = 13'(cnt_q);
        res_o.crc_match    = ({crc_hi_q, rx_byte_i} == crc_q);
        res_o.overflowed   = ovf_q;
      end
      default: ;
    endcase
    // kept byte goes out at once; past the limit it only flags overflow
    if (take_byte) begin
      if (room) begin
        cnt_d              = cnt_q + 1'b1;
        res_valid_o        = 1'b1;
        res_o.item_kind    = KIND_PAYLOAD;
        res_o.payload_byte = rx_byte_i;
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  // State registers advance on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_WAIT;
      crc_q    <= '0;
      crc_hi_q <= '0;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
    end else if (beat_i) begin
      phase_q  <= phase_d;
      crc_q    <= crc_d;
      crc_hi_q <= crc_hi_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule

// ===== src/byte_stuff_deframer_crc16_unit.sv =====
// Byte-stuffed frame deframer with CRC-16/ARC check: config registers and output stage.
// Depends on bsd_pkg, bsd_deframe_core and byte_stuff_deframer_crc16_unit_assert.svh.
// A result is registered: valid on the master side the cycle after its byte is taken.
// One byte per cycle unless a result waits unread; single output reg refills as read.
// Reset (async, active low): waits for a start code, CRC/count/flags cleared,
// registers return to start 0xFE, end 0xEF, escape 0xEA, max_length 4096.
`timescale 1ns / 1ps

`include "byte_stuff_deframer_crc16_unit_assert.svh"

module byte_stuff_deframer_crc16_unit import bsd_pkg::*; #(
  parameter int MAX_FRAME = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // receive byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // decoded items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [20:8] frame_length,
                                      // [21] crc_match, [22] overflowed, [23] zero
  output logic [0:0]  m_axis_tuser,   // [0] item_kind
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);

  cfg_t  cfg_q;
  logic  s_beat, cfg_beat;
  logic  res_valid;
  res_t  res;
  logic  m_valid_q;
  res_t  m_res_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_beat    = cfg_valid_i && cfg_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_code  <= 8'd254;
      cfg_q.end_code    <= 8'd239;
      cfg_q.escape_code <= 8'd234;
      cfg_q.max_length  <= 13'd4096;
    end else if (cfg_beat) begin
      unique case (cfg_index_i)
        REG_START_CODE:  cfg_q.start_code  <= cfg_data_i[7:0];
        REG_END_CODE:    cfg_q.end_code    <= cfg_data_i[7:0];
        REG_ESCAPE_CODE: cfg_q.escape_code <= cfg_data_i[7:0];
        REG_MAX_LENGTH:  cfg_q.max_length  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Take a byte whenever the output register is empty or being read
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign s_beat        = s_axis_tvalid && s_axis_tready;

  bsd_deframe_core #(
    .MAX_FRAME(MAX_FRAME)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .beat_i     (s_beat),
    .rx_byte_i  (s_axis_tdata),
    .cfg_i      (cfg_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_beat) begin
      m_valid_q <= res_valid;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_beat && res_valid) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_res_q.item_kind;
  assign m_axis_tdata  = {1'b0, m_res_q.overflowed, m_res_q.crc_match,
                          m_res_q.frame_length, m_res_q.payload_byte};

  // Checks
  `BSD_ASSERT_NEXT(a_result_lands, s_beat && res_valid, m_valid_q, "result beat lost")
  `BSD_ASSERT_NOW(a_payload_clean, m_valid_q && (m_res_q.item_kind == KIND_PAYLOAD), (m_res_q.frame_length == 13'd0) && !m_res_q.crc_match && !m_res_q.overflowed, "payload beat carries report fields")
  `BSD_ASSERT_NOW(a_report_clean, m_valid_q && (m_res_q.item_kind == KIND_END), m_res_q.payload_byte == 8'd0, "end report carries a payload byte")

endmodule
